// File: rtl/aoc_pkg.sv
package aoc_pkg;

    localparam int LANES  = 4;
    localparam int QBITS  = 8;
    localparam int SUM_W  = 17;
    localparam int NUM_W  = 25;
    localparam int WGT_W  = 16;
    localparam int ALPHA_LANE = 3;

    typedef struct packed {
        logic                            valid;
        logic                            clear;
        logic [SUM_W-1:0]                sum;
        logic [LANES-1:0][NUM_W-1:0]     rem;
        logic [LANES-1:0][QBITS-1:0]     quot;
    } aoc_stage_t;

endpackage

// File: rtl/aoc_weight.sv
module aoc_weight
    import aoc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [7:0]       top_red,
    input  logic [7:0]       top_green,
    input  logic [7:0]       top_blue,
    input  logic [7:0]       top_alpha,
    input  logic [7:0]       under_red,
    input  logic [7:0]       under_green,
    input  logic [7:0]       under_blue,
    input  logic [7:0]       under_alpha,
    output aoc_stage_t       stage_out
);

    logic                    a_valid_reg;
    logic [WGT_W-1:0]        w_top_reg;
    logic [WGT_W-1:0]        w_under_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [2:0][7:0]         c_top_reg;
    logic [2:0][7:0]         c_under_reg;
    logic [WGT_W-1:0]        w_top_next;
    logic [WGT_W-1:0]        w_under_next;
    logic [7:0]              a1_inv;
    logic [SUM_W-1:0]        alpha_sum;
    aoc_stage_t              stage_reg;
    aoc_stage_t              stage_next;

    assign a1_inv       = 8'd255 - top_alpha;
    assign w_top_next   = WGT_W'(top_alpha) * WGT_W'(8'd255);
    assign w_under_next = WGT_W'(a1_inv) * WGT_W'(under_alpha);

    // The sum never exceeds 255 * 255, where (x + 1 + (x >> 8)) >> 8 equals x / 255.
    assign alpha_sum    = sum_reg + SUM_W'(1) + (sum_reg >> 8);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_top_reg   <= w_top_next;
            w_under_reg <= w_under_next;
            sum_reg     <= SUM_W'(w_top_next) + SUM_W'(w_under_next);
            c_top_reg   <= {top_blue, top_green, top_red};
            c_under_reg <= {under_blue, under_green, under_red};
        end
    end

    always_comb
    begin
        stage_next       = '0;
        stage_next.valid = a_valid_reg;
        stage_next.clear = (sum_reg == '0);
        stage_next.sum   = sum_reg;
        for (int l = 0; l < 3; l++)
        begin
            stage_next.rem[l] = NUM_W'(w_under_reg * NUM_W'(c_under_reg[l]))
                              + NUM_W'(w_top_reg * NUM_W'(c_top_reg[l]));
        end
        stage_next.quot[ALPHA_LANE] = alpha_sum[2*QBITS-1:QBITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

// File: rtl/aoc_div_cell.sv
module aoc_div_cell
    import aoc_pkg::*;
#(
    parameter int BIT = QBITS - 1
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  aoc_stage_t   stage_in,
    output aoc_stage_t   stage_out
);

    aoc_stage_t stage_reg;
    aoc_stage_t stage_next;
    logic [NUM_W-1:0] divisor;

    always_comb
    begin
        stage_next = stage_in;
        divisor    = NUM_W'(stage_in.sum) << BIT;
        for (int l = 0; l < LANES; l++)
        begin
            if (l != ALPHA_LANE && stage_in.rem[l] >= divisor)
            begin
                stage_next.rem[l]       = stage_in.rem[l] - divisor;
                stage_next.quot[l][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

// File: rtl/alpha_over_composite_top.sv
// Porter-Duff over of two straight-alpha RGBA8 pixels, one word per clock. The
// weights and their sum are registered first, then the three color numerators and
// the output alpha; then a row of eight divider cells yields one quotient bit each
// for the three colors. The whole pipeline stalls together while the output word
// is not taken. When both alphas are zero all outputs are zero and fully_clear is
// set in tuser.
module alpha_over_composite_top
    import aoc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // top_red, top_green, top_blue, top_alpha,
    // under_red, under_green, under_blue, under_alpha
    input  logic [63:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [31:0]  m_axis_tdata,
    // fully_clear
    output logic [0:0]   m_axis_tuser
);

    logic       en;
    aoc_stage_t chain [QBITS+1];

    assign en            = !chain[QBITS].valid || m_axis_tready;
    assign s_axis_tready = en;

    aoc_weight u_weight (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (s_axis_tvalid),
        .top_red     (s_axis_tdata[7:0]),
        .top_green   (s_axis_tdata[15:8]),
        .top_blue    (s_axis_tdata[23:16]),
        .top_alpha   (s_axis_tdata[31:24]),
        .under_red   (s_axis_tdata[39:32]),
        .under_green (s_axis_tdata[47:40]),
        .under_blue  (s_axis_tdata[55:48]),
        .under_alpha (s_axis_tdata[63:56]),
        .stage_out   (chain[0])
    );

    for (genvar i = 0; i < QBITS; i++)
    begin : g_cell
        aoc_div_cell #(
            .BIT (QBITS - 1 - i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .stage_in  (chain[i]),
            .stage_out (chain[i+1])
        );
    end

    assign m_axis_tvalid = chain[QBITS].valid;
    assign m_axis_tuser  = chain[QBITS].clear;
    assign m_axis_tdata  = chain[QBITS].clear ? '0 : chain[QBITS].quot;

`ifndef SYNTHESIS
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("clear word carries nonzero data");

    a_alpha_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[31:24] != 8'd0)
        else $error("visible pixel with zero alpha");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");
`endif

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    typedef struct packed {
        logic [7:0] under_alpha;
        logic [7:0] under_blue;
        logic [7:0] under_green;
        logic [7:0] under_red;
        logic [7:0] top_alpha;
        logic [7:0] top_blue;
        logic [7:0] top_green;
        logic [7:0] top_red;
    } pixel_pair_t;

    typedef struct packed {
        logic       fully_clear;
        logic [7:0] out_alpha;
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
    } blend_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    pixel_pair_t pending_pairs[$];
    blend_t      expected_blends[$];
    int          error_count;
    int          hold_cycles;
    bit          hold_request;
    bit          gaps_enabled;
    bit          sending_done;

    alpha_over_composite_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] mix_channel(logic [31:0] w_top, logic [31:0] w_under,
                                               logic [7:0] c_top, logic [7:0] c_under,
                                               logic [31:0] total);
        logic [31:0] num;
        begin
            num = w_under * c_under + w_top * c_top;
            return 8'(num / total);
        end
    endfunction

    function automatic blend_t composite_over(pixel_pair_t p);
        logic [31:0] w_top;
        logic [31:0] w_under;
        logic [31:0] total;
        blend_t      r;
        begin
            w_top   = 32'(p.top_alpha) * 255;
            w_under = (255 - 32'(p.top_alpha)) * 32'(p.under_alpha);
            total   = w_top + w_under;
            r = '0;
            if (total == 0)
            begin
                r.fully_clear = 1'b1;
            end
            else
            begin
                r.out_red   = mix_channel(w_top, w_under, p.top_red, p.under_red, total);
                r.out_green = mix_channel(w_top, w_under, p.top_green, p.under_green, total);
                r.out_blue  = mix_channel(w_top, w_under, p.top_blue, p.under_blue, total);
                r.out_alpha = 8'(total / 255);
            end
            return r;
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        begin
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            error_count++;
        end
    endtask

    task automatic queue_pair(logic [7:0] tr, logic [7:0] tg, logic [7:0] tb, logic [7:0] ta,
                              logic [7:0] ur, logic [7:0] ug, logic [7:0] ub,
                              logic [7:0] ua);
        pixel_pair_t p;
        begin
            p = {ua, ub, ug, ur, ta, tb, tg, tr};
            pending_pairs.push_back(p);
        end
    endtask

    function automatic logic [7:0] random_alpha();
        int pick;
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                return 8'd0;
            else if (pick == 1)
                return 8'd255;
            else if (pick == 2)
                return 8'($urandom_range(0, 3));
            else
                return 8'($urandom);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pending_pairs.size() > 0 && !(gaps_enabled && $urandom_range(0, 99) < 28))
            begin
                s_axis_tdata  <= pending_pairs[0];
                expected_blends.push_back(composite_over(pending_pairs.pop_front()));
                s_axis_tvalid <= 1'b1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles   <= 0;
        end
        else if (hold_request && hold_cycles == 0)
        begin
            hold_cycles   <= 200;
            m_axis_tready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles   <= hold_cycles - 1;
            m_axis_tready <= (hold_cycles == 1);
        end
        else
        begin
            m_axis_tready <= !(gaps_enabled && $urandom_range(0, 99) < 28);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            blend_t got;
            blend_t want;
            got = {m_axis_tuser, m_axis_tdata};
            if (expected_blends.size() == 0)
            begin
                report_mismatch("unexpected word", int'(got), 0);
            end
            else
            begin
                want = expected_blends.pop_front();
                if (got.out_red !== want.out_red)
                    report_mismatch("out_red", got.out_red, want.out_red);
                if (got.out_green !== want.out_green)
                    report_mismatch("out_green", got.out_green, want.out_green);
                if (got.out_blue !== want.out_blue)
                    report_mismatch("out_blue", got.out_blue, want.out_blue);
                if (got.out_alpha !== want.out_alpha)
                    report_mismatch("out_alpha", got.out_alpha, want.out_alpha);
                if (got.fully_clear !== want.fully_clear)
                    report_mismatch("fully_clear", got.fully_clear, want.fully_clear);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("alpha_over_composite_top regression: fail");
        $finish;
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        error_count  = 0;
        hold_request = 1'b0;
        gaps_enabled = 1'b1;
        sending_done = 1'b0;

        queue_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        queue_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0);
        queue_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        queue_pair(8'd255, 8'd0, 8'd128, 8'd255, 8'd0, 8'd255, 8'd77, 8'd255);
        queue_pair(8'd10, 8'd20, 8'd30, 8'd0, 8'd200, 8'd100, 8'd50, 8'd255);
        queue_pair(8'd10, 8'd20, 8'd30, 8'd0, 8'd200, 8'd100, 8'd50, 8'd1);
        queue_pair(8'd255, 8'd255, 8'd255, 8'd1, 8'd0, 8'd0, 8'd0, 8'd255);
        queue_pair(8'd255, 8'd0, 8'd255, 8'd1, 8'd0, 8'd255, 8'd0, 8'd0);
        queue_pair(8'd0, 8'd255, 8'd0, 8'd128, 8'd255, 8'd0, 8'd255, 8'd128);
        queue_pair(8'd255, 8'd255, 8'd255, 8'd254, 8'd0, 8'd0, 8'd0, 8'd255);
        queue_pair(8'd170, 8'd85, 8'd51, 8'd127, 8'd85, 8'd170, 8'd204, 8'd1);
        queue_pair(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0);
        queue_pair(8'd1, 8'd254, 8'd128, 8'd64, 8'd254, 8'd1, 8'd127, 8'd192);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < 500; i++)
        begin
            queue_pair($urandom, $urandom, $urandom, random_alpha(),
                       $urandom, $urandom, $urandom, random_alpha());
        end

        wait (pending_pairs.size() < 420);
        @(posedge clk);
        hold_request <= 1'b1;
        @(posedge clk);
        hold_request <= 1'b0;
        wait (pending_pairs.size() < 300);
        gaps_enabled = 1'b0;
        wait (pending_pairs.size() < 150);
        gaps_enabled = 1'b1;
        wait (pending_pairs.size() == 0);
        wait (!s_axis_tvalid);
        wait (expected_blends.size() == 0);
        repeat (30) @(posedge clk);

        if (error_count == 0)
            $display("alpha_over_composite_top regression: pass");
        else
            $display("alpha_over_composite_top regression: fail");
        $finish;
    end

endmodule
